@@ sv/text_escape_line_numberer_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the text escape line numberer
// Shared checks written against the clock and synchronous reset.
// ---------------------------------------------------------------------------
`ifndef TEXT_ESCAPE_LINE_NUMBERER_DEFINES_SVH
`define TEXT_ESCAPE_LINE_NUMBERER_DEFINES_SVH

// Check a property at every clock edge outside reset
`define TELN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle
`define TELN_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ sv/teln_pkg.sv @@
// ---------------------------------------------------------------------------
// Text escape line numberer package
// Word types, character constants, render codes and shared helpers.
// ---------------------------------------------------------------------------
package teln_pkg;

   // Counter and layout constants
   localparam int MAX_DIGITS           = 7;
   localparam int COUNT_DIGITS_DEFAULT = 7;
   localparam int PAD_WIDTH            = 5;
   localparam int MAX_RESULTS          = 12;
   localparam int JOB_DEPTH_DEFAULT    = 4;
   localparam int POS_W                = $clog2(MAX_RESULTS);

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_NUMBER_LINES   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SHOW_CONTROLS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MARK_LINE_ENDS = 2'd2;

   // Characters
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_CARET     = 8'h5E;
   localparam logic [7:0] CH_AT        = 8'h40;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_VTAB      = 8'h0B;
   localparam logic [7:0] CH_FORMFEED  = 8'h0C;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] PRINT_LO     = 8'd32;
   localparam logic [7:0] PRINT_HI     = 8'd127;

   // Render codes
   localparam logic [1:0] KIND_PLAIN   = 2'd0;
   localparam logic [1:0] KIND_NL_MARK = 2'd1;
   localparam logic [1:0] KIND_CARET   = 2'd2;
   localparam logic [1:0] KIND_OCTAL   = 2'd3;

   typedef logic [MAX_DIGITS-1:0][3:0] digits_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       new_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic number_lines;
      logic show_controls;
      logic mark_line_ends;
   } cfg_type;

   // One classified input word, ready for the back end to expand
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       numbered;
      digits_type digits;
      logic [2:0] num_len;
      logic [2:0] num_width;
      logic [3:0] num_total;
   } job_type;

   // Number of characters in the rendering of a byte
   function automatic logic [2:0] render_len(input logic [1:0] kind);
      logic [2:0] len;
      unique case (kind)
         KIND_PLAIN:   len = 3'd1;
         KIND_NL_MARK: len = 3'd2;
         KIND_CARET:   len = 3'd2;
         KIND_OCTAL:   len = 3'd4;
         default:      len = 3'd1;
      endcase
      return len;
   endfunction

endpackage

@@ sv/teln_front.sv @@
// ---------------------------------------------------------------------------
// Front end
// Accepts input words, keeps the decimal line counter and classifies each
// byte into a render job for the back end.
// ---------------------------------------------------------------------------
module teln_front #(
   parameter int COUNT_DIGITS = teln_pkg::COUNT_DIGITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  teln_pkg::cfg_type cfg,
   input  logic              req_push,
   input  teln_pkg::req_type req_data,
   input  logic              job_full,
   output logic              job_push,
   output teln_pkg::job_type job_data
);
   import teln_pkg::*;

   localparam int EFF_DIGITS = (COUNT_DIGITS < MAX_DIGITS) ? COUNT_DIGITS : MAX_DIGITS;

   logic                       at_line_start_ff, at_line_start_in;
   logic [EFF_DIGITS-1:0][3:0] count_ff, count_in;
   logic [EFF_DIGITS-1:0][3:0] base, bumped;
   logic                       saturated, carry, numbered, printable, accept;
   logic [7:0]                 b;
   digits_type                 digits;
   logic [2:0]                 len, width;

   assign accept   = req_push && !job_full;
   assign job_push = accept;
   assign b        = req_data.in_byte;

   // Clear on a new stream, then bump the BCD count with saturation
   always_comb begin
      base      = req_data.new_stream ? '0 : count_ff;
      saturated = 1'b1;
      carry     = 1'b1;
      for (int i = 0; i < EFF_DIGITS; i++) begin
         if (base[i] != 4'd9) begin
            saturated = 1'b0;
         end
         if (carry) begin
            if (base[i] == 4'd9) begin
               bumped[i] = 4'd0;
            end else begin
               bumped[i] = base[i] + 4'd1;
               carry     = 1'b0;
            end
         end else begin
            bumped[i] = base[i];
         end
      end
      numbered = (req_data.new_stream || at_line_start_ff) && cfg.number_lines;
      count_in = (numbered && !saturated) ? bumped : base;
      at_line_start_in = (b == CH_NEWLINE);
   end

   // Find the significant digit count and the padded field width
   always_comb begin
      digits = '0;
      for (int i = 0; i < EFF_DIGITS; i++) begin
         digits[i] = count_in[i];
      end
      len = 3'd1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (digits[i] != 4'd0) begin
            len = 3'(i + 1);
         end
      end
      width = (len < 3'(PAD_WIDTH)) ? 3'(PAD_WIDTH) : len;
   end

   // Classify the byte
   always_comb begin
      printable = ((b >= PRINT_LO) && (b <= PRINT_HI)) || (b == CH_TAB) ||
                  (b == CH_VTAB) || (b == CH_FORMFEED) || (b == CH_RETURN);
      job_data           = '0;
      job_data.data      = b;
      job_data.numbered  = numbered;
      job_data.digits    = digits;
      job_data.num_len   = len;
      job_data.num_width = width;
      job_data.num_total = numbered ? ({1'b0, width} + 4'd1) : 4'd0;
      if (b == CH_NEWLINE) begin
         job_data.kind = cfg.mark_line_ends ? KIND_NL_MARK : KIND_PLAIN;
      end else if (printable || !cfg.show_controls) begin
         job_data.kind = KIND_PLAIN;
      end else if (b < PRINT_LO) begin
         job_data.kind = KIND_CARET;
      end else begin
         job_data.kind = KIND_OCTAL;
      end
   end

   // Advance line state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff <= 1'b1;
         count_ff         <= '0;
      end else if (accept) begin
         at_line_start_ff <= at_line_start_in;
         count_ff         <= count_in;
      end
   end

endmodule

@@ sv/teln_queue.sv @@
// ---------------------------------------------------------------------------
// Job queue
// Short register queue between the front end and the back end.
// ---------------------------------------------------------------------------
`include "text_escape_line_numberer_defines.svh"

module teln_queue #(
   parameter int DEPTH = teln_pkg::JOB_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  teln_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output teln_pkg::job_type pop_data,
   output logic              empty
);
   import teln_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = slots_ff[rd_ptr_ff];

   // Wrap pointers and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TELN_ASSERT(a_count_bound, count_ff <= FULL_CNT, "job queue count out of range")
   `TELN_ASSERT(a_no_overflow, !(push && full), "job queue push while full")
   `TELN_ASSERT(a_no_underflow, !(pop && empty), "job queue pop while empty")

endmodule

@@ sv/teln_back.sv @@
// ---------------------------------------------------------------------------
// Back end
// Expands each job into its characters and loads them into the output
// register, one per cycle while that register is empty or being read.
// ---------------------------------------------------------------------------
`include "text_escape_line_numberer_defines.svh"

module teln_back (
   input  logic              clock,
   input  logic              reset,
   input  teln_pkg::job_type job_data,
   input  logic              job_empty,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output teln_pkg::rsp_type rsp_data
);
   import teln_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_data_ff, out_data_in;
   rsp_type          ch;
   logic             load;
   logic [2:0]       k, rlen;
   logic [3:0]       rel;
   logic [1:0]       r;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign load      = !job_empty && (!out_valid_ff || rsp_pop);
   assign job_pop   = load && ch.last;

   // Pick the character at the current position of the job
   always_comb begin
      ch   = '0;
      k    = job_data.num_width - 3'd1 - pos_ff[2:0];
      rel  = 4'(pos_ff) - job_data.num_total;
      r    = rel[1:0];
      rlen = render_len(job_data.kind);
      if (job_data.numbered && (4'(pos_ff) < {1'b0, job_data.num_width})) begin
         ch.out_byte = (k < job_data.num_len) ? (CH_ZERO + {4'd0, job_data.digits[k]})
                                              : CH_SPACE;
      end else if (job_data.numbered && (4'(pos_ff) == {1'b0, job_data.num_width})) begin
         ch.out_byte = CH_SPACE;
      end else begin
         ch.last = ({1'b0, r} + 3'd1) == rlen;
         case (job_data.kind)
            KIND_NL_MARK: ch.out_byte = (r == 2'd0) ? CH_DOLLAR : job_data.data;
            KIND_CARET:   ch.out_byte = (r == 2'd0) ? CH_CARET : (job_data.data + CH_AT);
            KIND_OCTAL: begin
               case (r)
                  2'd0:    ch.out_byte = CH_BACKSLASH;
                  2'd1:    ch.out_byte = CH_ZERO + {6'd0, job_data.data[7:6]};
                  2'd2:    ch.out_byte = CH_ZERO + {5'd0, job_data.data[5:3]};
                  default: ch.out_byte = CH_ZERO + {5'd0, job_data.data[2:0]};
               endcase
            end
            default:      ch.out_byte = job_data.data;
         endcase
      end
   end

   // Load the output register, advance or restart the position
   always_comb begin
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_data_in  = out_data_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_data_in  = ch;
         pos_in       = ch.last ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   `TELN_ASSERT(a_pos_bound, pos_ff < POS_W'(MAX_RESULTS), "render position out of range")
   `TELN_ASSERT_IMP(a_mid_job, pos_ff != '0, !job_empty, "render position set with no job")
   `TELN_ASSERT_IMP(a_pop_last, job_pop, load && ch.last, "job dropped before its last word")

endmodule

@@ sv/text_escape_line_numberer.sv @@
// ---------------------------------------------------------------------------
// Text escape line numberer
// Renders a text byte stream with optional line numbers, end-of-line marks
// and caret / octal forms for control and high bytes.
// ---------------------------------------------------------------------------
//   Channel   Ports                              Word
//   request   req_push / req_full / req_data     one raw byte + new stream flag
//   response  rsp_pop / rsp_empty / rsp_data     one rendered character + last
//   config    csr_we / csr_index / csr_wdata     one register bit
//
// The front end takes one byte per cycle while the job queue has room; the
// back end emits one character per cycle while the output register is free
// or being read. A byte renders to 1 to 12 characters (a number field of 6
// to 8 plus a rendering of 1 to 4). Characters pass through the output
// register to the response ports; response stalls fill the job queue, then
// raise req_full. Synchronous reset empties the queue and output register
// and clears the line count and configuration; no clearing pass is needed.
// ---------------------------------------------------------------------------
module text_escape_line_numberer #(
   parameter int COUNT_DIGITS = teln_pkg::COUNT_DIGITS_DEFAULT,
   parameter int JOB_DEPTH    = teln_pkg::JOB_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  teln_pkg::req_type                   req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output teln_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [teln_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [teln_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import teln_pkg::*;

   cfg_type cfg_ff, cfg_in;
   job_type push_job, head_job;
   logic    job_push, job_pop, job_full, job_empty;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_NUMBER_LINES:   cfg_in.number_lines   = csr_wdata[0];
            REG_SHOW_CONTROLS:  cfg_in.show_controls  = csr_wdata[0];
            REG_MARK_LINE_ENDS: cfg_in.mark_line_ends = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = job_full;

   teln_front #(
      .COUNT_DIGITS (COUNT_DIGITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .job_full (job_full),
      .job_push (job_push),
      .job_data (push_job)
   );

   teln_queue #(
      .DEPTH (JOB_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (head_job),
      .empty     (job_empty)
   );

   teln_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (head_job),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/sv/tb.sv @@
// ---------------------------------------------------------------------------
// Testbench for the text escape line numberer
// Sends raw text bytes through the request queue and checks every rendered
// character against an in-bench model of line numbering, end marks and
// caret / octal forms. Covers register settings, random gaps on both sides
// and a long response stall.
// ---------------------------------------------------------------------------
module tb;
   import teln_pkg::*;

   localparam int          COUNT_DIGITS  = COUNT_DIGITS_DEFAULT;
   localparam int unsigned COUNT_CEILING =
      (COUNT_DIGITS >= 7) ? 32'd9999999 : 10**COUNT_DIGITS - 1;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS  = 200;
   localparam int SEGMENT_ITEMS = 40;
   localparam int HOLD_CYCLES   = 250;
   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_push   = 1'b0;
   logic                   req_full;
   req_type                req_data   = '0;
   logic                   rsp_empty;
   logic                   rsp_pop    = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Model state
   cfg_type     render_cfg = '0;
   logic        line_start = 1'b1;
   logic [23:0] line_count = '0;
   rsp_type     expected_chars [$];

   // Traffic control shared between the sender, the receiver and the tests
   bit          send_idle       = 1'b0;
   bit          recv_idle       = 1'b0;
   int          rsp_hold_cycles = 0;
   int          error_count     = 0;
   int          quiet_cycles    = 0;

   text_escape_line_numberer #(
      .COUNT_DIGITS (COUNT_DIGITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // End the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Expand one accepted byte into its expected characters
   task automatic render_byte(input req_type w);
      logic [7:0] b;
      logic [7:0] text [$];
      string      prefix;
      rsp_type    ch;
      b = w.in_byte;
      if (w.new_stream) begin
         line_count = '0;
         line_start = 1'b1;
      end
      if (line_start && render_cfg.number_lines) begin
         if (line_count < COUNT_CEILING)
            line_count = line_count + 24'd1;
         else
            line_count = 24'(COUNT_CEILING);
         prefix = $sformatf("%5d ", line_count);
         for (int i = 0; i < prefix.len(); i++)
            text.push_back(prefix[i]);
      end
      if (b == CH_NEWLINE) begin
         if (render_cfg.mark_line_ends)
            text.push_back(CH_DOLLAR);
         text.push_back(b);
      end else if ((b >= PRINT_LO && b <= PRINT_HI) || b == CH_TAB || b == CH_VTAB ||
                   b == CH_FORMFEED || b == CH_RETURN) begin
         text.push_back(b);
      end else if (render_cfg.show_controls && b < PRINT_LO) begin
         text.push_back(CH_CARET);
         text.push_back(b + CH_AT);
      end else if (render_cfg.show_controls) begin
         text.push_back(CH_BACKSLASH);
         text.push_back(CH_ZERO + {6'd0, b[7:6]});
         text.push_back(CH_ZERO + {5'd0, b[5:3]});
         text.push_back(CH_ZERO + {5'd0, b[2:0]});
      end else begin
         text.push_back(b);
      end
      line_start = (b == CH_NEWLINE);
      foreach (text[i]) begin
         ch.out_byte = text[i];
         ch.last     = (i == text.size() - 1);
         expected_chars.push_back(ch);
      end
   endtask

   // Offer one word and hold it until the block takes it; call at a falling edge
   task automatic send_word(input logic [7:0] b, input logic fresh);
      req_type w;
      int      gap;
      w.in_byte    = b;
      w.new_stream = fresh;
      gap = send_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
      render_byte(w);
      @(negedge clock);
   endtask

   // Drop the request and wait until every expected character has arrived
   task automatic settle_pipeline();
      req_push <= 1'b0;
      while (expected_chars.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] index, input logic value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // Write all registers while idle, plus the unused index, which must be ignored
   task automatic apply_settings(input cfg_type c);
      settle_pipeline();
      put_reg(REG_NUMBER_LINES, c.number_lines);
      put_reg(REG_SHOW_CONTROLS, c.show_controls);
      put_reg(REG_MARK_LINE_ENDS, c.mark_line_ends);
      put_reg(REG_UNUSED, 1'($urandom_range(0, 1)));
      csr_we <= 1'b0;
      render_cfg = c;
   endtask

   // Receive and check results, with random gaps and an optional long hold
   initial begin
      int      gap;
      rsp_type want;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         gap = recv_idle ? $urandom_range(0, 9) : 0;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (expected_chars.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected character %02h last %0b", rsp_data.out_byte,
                        rsp_data.last);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("out_byte mismatch: expected %02h, got %02h",
                           want.out_byte, rsp_data.out_byte);
            end
            if (rsp_data.last !== want.last) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("last mismatch on %02h: expected %0b, got %0b",
                           want.out_byte, want.last, rsp_data.last);
            end
         end
         @(negedge clock);
      end
   end

   // Registers at reset: every byte passes through unchanged
   task automatic test_reset_defaults();
      logic [7:0] text [$];
      text = {8'h00, 8'hFF, 8'h0A, 8'h41, 8'h1B, 8'h80};
      foreach (text[i])
         send_word(text[i], 1'b0);
   endtask

   // Every rendering with all options on, including a stream restart on the last line
   task automatic test_all_renderings();
      logic [7:0] text [$];
      send_idle = 1'b1;
      recv_idle = 1'b1;
      apply_settings('{number_lines: 1'b1, show_controls: 1'b1, mark_line_ends: 1'b1});
      text = {8'h00, 8'h1F, 8'h09, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h7F, 8'h80, 8'hFF,
              8'h0A, 8'h0A, 8'h41, 8'h0A, 8'h42};
      foreach (text[i])
         send_word(text[i], i == 0 || i == text.size() - 1);
      send_word(8'h0A, 1'b0);
   endtask

   // Stall the receiver for a long stretch so the block fills and raises full
   task automatic test_backpressure();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      apply_settings('{number_lines: 1'b1, show_controls: 1'b1, mark_line_ends: 1'b0});
      rsp_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 40; i++)
         send_word((i % 5 == 4) ? CH_NEWLINE : 8'($urandom_range(0, 255)), 1'b0);
   endtask

   // Random text in segments, each with its own settings and idling
   task automatic test_random_text();
      cfg_type    c;
      logic [7:0] b;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_ITEMS == 0) begin
            if (n == 0)
               c = '1;
            else if (n == SEGMENT_ITEMS)
               c = '0;
            else
               c = 3'($urandom_range(0, 7));
            apply_settings(c);
            send_idle = ($urandom_range(0, 2) != 0);
            recv_idle = ($urandom_range(0, 2) != 0);
         end
         case ($urandom_range(0, 15))
            0, 1, 2:          b = CH_NEWLINE;
            3, 4, 5, 6, 7:    b = 8'($urandom_range(32, 127));
            8, 9: begin
               case ($urandom_range(0, 3))
                  0:       b = CH_TAB;
                  1:       b = CH_VTAB;
                  2:       b = CH_FORMFEED;
                  default: b = CH_RETURN;
               endcase
            end
            10, 11:           b = 8'($urandom_range(0, 31));
            12, 13:           b = 8'($urandom_range(128, 255));
            default:          b = 8'($urandom_range(0, 255));
         endcase
         send_word(b, $urandom_range(0, 19) == 0);
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_all_renderings();
      test_backpressure();
      test_random_text();
      settle_pipeline();
      if (error_count == 0 && expected_chars.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
